@@ src/rdd_pkg.sv @@
// shared types, constants and per-date stage functions for the date difference pipeline
// used by relative_date_difference; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DNUM_W  = 23;   // day number of any 14-bit year fits here
  localparam int unsigned COUNT_W = 22;

  localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = 23'd365;
  localparam logic [12:0]        RECIP_100     = 13'd5243;  // 2^19 / 100, rounded up
  localparam int unsigned        RECIP_SHIFT   = 19;
  localparam logic [6:0]         CENTURY       = 7'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 22'd4194303;
  localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;

  typedef enum logic [2:0] {
    KIND_TODAY     = 3'd0,
    KIND_YESTERDAY = 3'd1,
    KIND_SAME_MON  = 3'd2,
    KIND_SAME_YEAR = 3'd3,
    KIND_OTHER_YR  = 3'd4,
    KIND_ORDER_ERR = 3'd5
  } label_kind_t;

  // first stage: date with the month clamped, and the year quotients
  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [DNUM_W-1:0]  y365;
    logic [12:0]        c4;     // ceil(y/4)
    logic [7:0]         c100;   // ceil(y/100)
    logic [5:0]         c400;   // ceil(y/400)
    logic [7:0]         q100;   // floor(y/100)
  } date_s1_t;

  // second stage: days before the year and leap flag
  typedef struct packed {
    logic [DNUM_W-1:0]  dby;
    logic               leap;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
  } date_s2_t;

  // date equality flags carried down the pipe
  typedef struct packed {
    logic yeq;
    logic meq;
    logic deq;
  } date_eq_t;

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    if (m < MONTH_FIRST) r = MONTH_FIRST;
    else if (m > MONTH_LAST) r = MONTH_LAST;
    else r = m;
    return r;
  endfunction

  // floor(x/100) by reciprocal, exact for x below 25600 (8-bit result)
  function automatic logic [7:0] div100(input logic [YEAR_W:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP_100);
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic date_s1_t date_stage1(input logic [YEAR_W-1:0]  y,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [DAY_W-1:0]   d);
    date_s1_t   s;
    logic [7:0] q399;
    logic [YEAR_W:0] y3;
    s.y    = y;
    s.m    = clamp_month(m);
    s.d    = d;
    s.y365 = DNUM_W'(y) * DAYS_PER_YEAR;
    y3     = (YEAR_W+1)'(y) + 15'd3;
    s.c4   = y3[YEAR_W:2];
    s.c100 = div100((YEAR_W+1)'(y) + 15'd99);
    q399   = div100((YEAR_W+1)'(y) + 15'd399);
    s.c400 = q399[7:2];
    s.q100 = div100((YEAR_W+1)'(y));
    return s;
  endfunction

  function automatic date_s2_t date_stage2(input date_s1_t s);
    date_s2_t        r;
    logic [YEAR_W-1:0] rem;
    rem    = s.y - YEAR_W'(s.q100) * YEAR_W'(CENTURY);
    r.dby  = s.y365 + DNUM_W'(s.c4) + DNUM_W'(s.c400) - DNUM_W'(s.c100);
    r.leap = (s.y[1:0] == 2'b00) && ((rem != '0) || (s.q100[1:0] == 2'b00));
    r.m    = s.m;
    r.d    = s.d;
    return r;
  endfunction

  function automatic logic [DNUM_W-1:0] date_stage3(input date_s2_t s);
    return s.dby + DNUM_W'(days_before_month(s.m)) + DNUM_W'(s.d)
           + DNUM_W'((s.m > MONTH_FEB) && s.leap);
  endfunction

endpackage

`default_nettype wire

@@ src/relative_date_difference.sv @@
// days between two gregorian dates with a label class, four register stages
// depends on rdd_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   input channel: in_valid / in_stall carry one request, a pair of dates
//   (first_* and ref_*). output channel: out_valid / out_stall carry
//   label_kind and day_count for that request, in request order.
//   a request passes the stages in order (month clamp and year quotients,
//   days before year and leap flag, day numbers, difference and label)
//   before it shows on the outputs. throughput: one request per cycle while
//   out_stall is low; each stage is a plain register with a valid bit, so
//   the pipe never waits on itself.
//   stalls: out_stall freezes the output register; a stage moves only when
//   it is empty or the stage after it moves, so bubbles are squeezed out and
//   in_stall rises only when all four stages hold requests.
//   reset: rst clears every valid bit; no request is in flight afterwards.
//   an earlier date after the reference date gives the order error label
//   with a zero count; counts saturate at the 22-bit maximum.

module relative_date_difference (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] first_year,
  input  wire logic [3:0]  first_month,
  input  wire logic [4:0]  first_day,
  input  wire logic [13:0] ref_year,
  input  wire logic [3:0]  ref_month,
  input  wire logic [4:0]  ref_day,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       label_kind,
  output logic [21:0]      day_count
);

  logic v1, v2, v3;
  logic move1, move2, move3, move4;

  rdd_pkg::date_s1_t a1, b1;
  rdd_pkg::date_s2_t a2, b2;
  logic [rdd_pkg::DNUM_W-1:0] n1, n2;
  rdd_pkg::date_eq_t eq1, eq2, eq3;

  rdd_pkg::date_s1_t a1_next, b1_next;
  rdd_pkg::date_eq_t eq1_next;
  rdd_pkg::label_kind_t kind_next;
  logic [rdd_pkg::COUNT_W-1:0] count_next;
  logic [rdd_pkg::DNUM_W-1:0]  diff;

  assign move4    = !out_valid || !out_stall;
  assign move3    = !v3 || move4;
  assign move2    = !v2 || move3;
  assign move1    = !v1 || move2;
  assign in_stall = !move1;

  always_comb begin
    a1_next      = rdd_pkg::date_stage1(first_year, first_month, first_day);
    b1_next      = rdd_pkg::date_stage1(ref_year, ref_month, ref_day);
    eq1_next.yeq = (first_year == ref_year);
    eq1_next.meq = (a1_next.m == b1_next.m);
    eq1_next.deq = (first_day == ref_day);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move1) v1 <= in_valid;
      if (move2) v2 <= v1;
      if (move3) v3 <= v2;
      if (move4) out_valid <= v3;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (move1) begin
      a1  <= a1_next;
      b1  <= b1_next;
      eq1 <= eq1_next;
    end
    if (move2) begin
      a2  <= rdd_pkg::date_stage2(a1);
      b2  <= rdd_pkg::date_stage2(b1);
      eq2 <= eq1;
    end
    if (move3) begin
      n1  <= rdd_pkg::date_stage3(a2);
      n2  <= rdd_pkg::date_stage3(b2);
      eq3 <= eq2;
    end
    if (move4) begin
      label_kind <= kind_next;
      day_count  <= count_next;
    end
  end

  always_comb begin
    diff = n2 - n1;
    if (n2 < n1) begin
      kind_next  = rdd_pkg::KIND_ORDER_ERR;
      count_next = '0;
    end else begin
      if (eq3.yeq && eq3.meq && eq3.deq) kind_next = rdd_pkg::KIND_TODAY;
      else if (diff == rdd_pkg::DNUM_W'(1)) kind_next = rdd_pkg::KIND_YESTERDAY;
      else if (eq3.yeq && eq3.meq) kind_next = rdd_pkg::KIND_SAME_MON;
      else if (eq3.yeq) kind_next = rdd_pkg::KIND_SAME_YEAR;
      else kind_next = rdd_pkg::KIND_OTHER_YR;
      if (diff > rdd_pkg::DNUM_W'(rdd_pkg::COUNT_MAX)) count_next = rdd_pkg::COUNT_MAX;
      else count_next = diff[rdd_pkg::COUNT_W-1:0];
    end
  end

  // in_stall only with a full pipe
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_valid))
    else $error("input stalled while a stage was empty");

  a_order_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && label_kind == rdd_pkg::KIND_ORDER_ERR) |-> (day_count == '0))
    else $error("order error with nonzero count");

  a_today_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && label_kind == rdd_pkg::KIND_TODAY) |-> (day_count == '0))
    else $error("same date with nonzero count");

  a_yesterday_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && label_kind == rdd_pkg::KIND_YESTERDAY)
      |-> (day_count == rdd_pkg::COUNT_W'(1)))
    else $error("yesterday label without a one-day count");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_stall) |=> out_valid)
    else $error("request lost between last stage and output");

endmodule

`default_nettype wire

@@ test/relative_date_difference_test.sv @@
// self-checking bench for relative_date_difference: directed date pairs, then random ones
// under sender idling, receiver stalls and a long output hold; depends on rdd_pkg
`timescale 1ns / 1ps

module relative_date_difference_test;

  typedef struct packed {
    logic [rdd_pkg::YEAR_W-1:0]  first_year;
    logic [rdd_pkg::MONTH_W-1:0] first_month;
    logic [rdd_pkg::DAY_W-1:0]   first_day;
    logic [rdd_pkg::YEAR_W-1:0]  ref_year;
    logic [rdd_pkg::MONTH_W-1:0] ref_month;
    logic [rdd_pkg::DAY_W-1:0]   ref_day;
  } date_pair_t;

  typedef struct packed {
    rdd_pkg::label_kind_t        kind;
    logic [rdd_pkg::COUNT_W-1:0] count;
  } date_gap_t;

  typedef struct packed {
    date_pair_t pair;
    logic       typed;
    date_gap_t  gap;
  } pair_row_t;

  localparam int unsigned CUM_DAYS [1:12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int RANDOM_PAIRS = 1450;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_ROWS     = 22;

  // rows with typed == 1 carry their own expected result, the rest go through the predictor
  localparam pair_row_t PAIR_ROWS [0:NUM_ROWS-1] = '{
    '{'{14'd2024, 4'd3, 5'd15, 14'd2024, 4'd3, 5'd15}, 1'b1, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31}, 1'b1,
      '{rdd_pkg::KIND_OTHER_YR, 22'd3652058}},
    '{'{14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_ORDER_ERR, 22'd0}},
    '{'{14'd0, 4'd0, 5'd0, 14'd16383, 4'd15, 5'd31}, 1'b1,
      '{rdd_pkg::KIND_OTHER_YR, 22'd4194303}},
    '{'{14'd16383, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0}, 1'b1,
      '{rdd_pkg::KIND_ORDER_ERR, 22'd0}},
    '{'{14'd2023, 4'd12, 5'd31, 14'd2024, 4'd1, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_YESTERDAY, 22'd1}},
    '{'{14'd2024, 4'd2, 5'd28, 14'd2024, 4'd2, 5'd29}, 1'b1,
      '{rdd_pkg::KIND_YESTERDAY, 22'd1}},
    '{'{14'd2024, 4'd2, 5'd29, 14'd2024, 4'd3, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_YESTERDAY, 22'd1}},
    '{'{14'd2023, 4'd2, 5'd28, 14'd2023, 4'd3, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_YESTERDAY, 22'd1}},
    '{'{14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_YESTERDAY, 22'd1}},
    '{'{14'd2000, 4'd2, 5'd28, 14'd2000, 4'd3, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_SAME_YEAR, 22'd2}},
    // feb 31 lands on mar 3
    '{'{14'd2023, 4'd2, 5'd31, 14'd2023, 4'd3, 5'd3}, 1'b1,
      '{rdd_pkg::KIND_SAME_YEAR, 22'd0}},
    // month 0 reads as january, 13..15 as december
    '{'{14'd2023, 4'd0, 5'd5, 14'd2023, 4'd1, 5'd5}, 1'b1, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2023, 4'd15, 5'd20, 14'd2023, 4'd12, 5'd20}, 1'b1,
      '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2023, 4'd13, 5'd7, 14'd2023, 4'd14, 5'd7}, 1'b1, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2023, 4'd3, 5'd2, 14'd2023, 4'd3, 5'd1}, 1'b1,
      '{rdd_pkg::KIND_ORDER_ERR, 22'd0}},
    '{'{14'd2023, 4'd3, 5'd0, 14'd2023, 4'd2, 5'd28}, 1'b0, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2023, 4'd3, 5'd0, 14'd2023, 4'd2, 5'd31}, 1'b0, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd0, 4'd2, 5'd28, 14'd0, 4'd3, 5'd1}, 1'b0, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2024, 4'd5, 5'd1, 14'd2024, 4'd5, 5'd31}, 1'b0, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd2024, 4'd1, 5'd1, 14'd2024, 4'd12, 5'd31}, 1'b0, '{rdd_pkg::KIND_TODAY, 22'd0}},
    '{'{14'd5461, 4'd10, 5'd21, 14'd10922, 4'd5, 5'd10}, 1'b0,
      '{rdd_pkg::KIND_TODAY, 22'd0}}
  };

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [rdd_pkg::YEAR_W-1:0]  first_year = '0;
  logic [rdd_pkg::MONTH_W-1:0] first_month = '0;
  logic [rdd_pkg::DAY_W-1:0]   first_day = '0;
  logic [rdd_pkg::YEAR_W-1:0]  ref_year = '0;
  logic [rdd_pkg::MONTH_W-1:0] ref_month = '0;
  logic [rdd_pkg::DAY_W-1:0]   ref_day = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [2:0]                  label_kind;
  logic [rdd_pkg::COUNT_W-1:0] day_count;

  date_gap_t gaps_due [$];
  int        errors = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;
  logic      hold_ask = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;

  relative_date_difference dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .first_year (first_year),
    .first_month(first_month),
    .first_day  (first_day),
    .ref_year   (ref_year),
    .ref_month  (ref_month),
    .ref_day    (ref_day),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .label_kind (label_kind),
    .day_count  (day_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned fix_month(input int unsigned m);
    if (m < 1) return 1;
    if (m > 12) return 12;
    return m;
  endfunction

  function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 12) return 31;
    return CUM_DAYS[m+1] - CUM_DAYS[m];
  endfunction

  // days from the start of proleptic year 0, month clamped, day taken linearly
  function automatic int unsigned day_index(input int unsigned y, input int unsigned m_raw,
                                            input int unsigned d);
    int unsigned m;
    int unsigned n;
    m = fix_month(m_raw);
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + CUM_DAYS[m] + d;
    if (m > 2 && is_leap(y)) n = n + 1;
    return n;
  endfunction

  function automatic date_gap_t predict_gap(input date_pair_t p);
    int unsigned n1;
    int unsigned n2;
    int unsigned gap;
    int unsigned m1;
    int unsigned m2;
    date_gap_t   r;
    m1 = fix_month(p.first_month);
    m2 = fix_month(p.ref_month);
    n1 = day_index(p.first_year, p.first_month, p.first_day);
    n2 = day_index(p.ref_year, p.ref_month, p.ref_day);
    if (n2 < n1) begin
      r.kind  = rdd_pkg::KIND_ORDER_ERR;
      r.count = '0;
    end else begin
      gap = n2 - n1;
      if (p.first_year == p.ref_year && m1 == m2 && p.first_day == p.ref_day)
        r.kind = rdd_pkg::KIND_TODAY;
      else if (gap == 1) r.kind = rdd_pkg::KIND_YESTERDAY;
      else if (p.first_year == p.ref_year && m1 == m2) r.kind = rdd_pkg::KIND_SAME_MON;
      else if (p.first_year == p.ref_year) r.kind = rdd_pkg::KIND_SAME_YEAR;
      else r.kind = rdd_pkg::KIND_OTHER_YR;
      r.count = (gap > 32'(rdd_pkg::COUNT_MAX)) ? rdd_pkg::COUNT_MAX
                                                 : gap[rdd_pkg::COUNT_W-1:0];
    end
    return r;
  endfunction

  function automatic date_pair_t swap_dates(input date_pair_t p);
    return '{p.ref_year, p.ref_month, p.ref_day, p.first_year, p.first_month, p.first_day};
  endfunction

  function automatic bool_later_first(input date_pair_t p);
    return day_index(p.ref_year, p.ref_month, p.ref_day)
           < day_index(p.first_year, p.first_month, p.first_day);
  endfunction

  task automatic rand_date(output int unsigned y, output int unsigned m,
                           output int unsigned d);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_len(y, m));
  endtask

  task automatic make_pair(output date_pair_t p);
    int unsigned y1, m1, d1, y2, m2, d2;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    rand_date(y1, m1, d1);
    rand_date(y2, m2, d2);
    if (pick < 8) begin
      y2 = y1; m2 = m1; d2 = d1;
    end else if (pick < 20) begin
      // one day apart, often across a month or year boundary
      if ($urandom_range(0, 1)) d1 = month_len(y1, m1);
      y2 = y1; m2 = m1; d2 = d1 + 1;
      if (d1 == month_len(y1, m1)) begin
        d2 = 1;
        if (m1 == 12) begin
          m2 = 1; y2 = y1 + 1;
        end else begin
          m2 = m1 + 1;
        end
      end
    end else if (pick < 32) begin
      y2 = y1; m2 = m1; d2 = $urandom_range(1, month_len(y1, m1));
    end else if (pick < 44) begin
      y2 = y1; d2 = (d2 > month_len(y2, m2)) ? month_len(y2, m2) : d2;
    end else if (pick < 80 && pick >= 74) begin
      // long span that can reach the count ceiling
      y1 = $urandom_range(0, 500);
      y2 = $urandom_range(11400, 16383);
    end else if (pick >= 80 && pick < 90) begin
      y1 = $urandom_range(0, 16383); m1 = $urandom_range(0, 15); d1 = $urandom_range(0, 31);
      y2 = $urandom_range(0, 16383); m2 = $urandom_range(0, 15); d2 = $urandom_range(0, 31);
    end
    p = '{y1[rdd_pkg::YEAR_W-1:0], m1[rdd_pkg::MONTH_W-1:0], d1[rdd_pkg::DAY_W-1:0],
          y2[rdd_pkg::YEAR_W-1:0], m2[rdd_pkg::MONTH_W-1:0], d2[rdd_pkg::DAY_W-1:0]};
    if (pick >= 90) begin
      if (!bool_later_first(p)) p = swap_dates(p);
    end else if (pick < 80 && $urandom_range(0, 99) < 85) begin
      if (bool_later_first(p)) p = swap_dates(p);
    end
  endtask

  task automatic offer_pair(input date_pair_t p, input logic typed, input date_gap_t given);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    first_year  <= p.first_year;
    first_month <= p.first_month;
    first_day   <= p.first_day;
    ref_year    <= p.ref_year;
    ref_month   <= p.ref_month;
    ref_day     <= p.ref_day;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    gaps_due.push_back(typed ? given : predict_gap(p));
  endtask

  // output side: random stalls plus one long hold-off that backs up the pipe
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    date_gap_t want;
    if (!rst && out_valid && !out_stall) begin
      if (gaps_due.size() == 0) begin
        $error("result with no request pending: label_kind %0d, day_count %0d",
               label_kind, day_count);
        errors++;
      end else begin
        want = gaps_due.pop_front();
        if (label_kind !== want.kind) begin
          $error("label_kind: expected %0d, got %0d", want.kind, label_kind);
          errors++;
        end
        if (day_count !== want.count) begin
          $error("day_count: expected %0d, got %0d", want.count, day_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    date_pair_t p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (PAIR_ROWS[i])
      offer_pair(PAIR_ROWS[i].pair, PAIR_ROWS[i].typed, PAIR_ROWS[i].gap);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          hold_ask      = 1'b1;
        end
        1: begin
          snd_idle_pct  = 47;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 47;
        end
        default: begin
          snd_idle_pct  = 23;
          rcv_stall_pct = 23;
        end
      endcase
      for (int n = 0; n < RANDOM_PAIRS / 4; n++) begin
        make_pair(p);
        offer_pair(p, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    rcv_stall_pct = 0;
    while (gaps_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0 && gaps_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
